FILE: rtl/core/tpsp_pkg.sv
package tpsp_pkg;

    // Travel in encoder counts: floor(amount * scale / 256), fits 16 bits signed
    localparam int TRAVEL_W = 16;
    // Travel magnitude, at most 16384
    localparam int T_W = 15;
    // Distance magnitude, capped at 2^32
    localparam int MAG_W = 33;
    // Signed distance wide enough for three times the capped distance
    localparam int P_W = MAG_W + 3;
    // Three times the speed span magnitude
    localparam int K_W = 17;
    // Ramp numerator: K_W x MAG_W product
    localparam int NUM_W = K_W + MAG_W;
    // Signed speed sum before saturation
    localparam int S_W = NUM_W + 2;
    // Divider step counter
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [63:0] DIST_CAP = 64'h0000_0001_0000_0000;

    // Profile phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ACCEL  = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;
    localparam logic [1:0] PH_DECEL  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_MIN_SPEED   = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_TURN_SCALE  = 2'd2;
    localparam logic [1:0] REG_DRIVE_SCALE = 2'd3;

    // Item kinds
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

endpackage

FILE: rtl/core/tpsp_div.sv
// Restoring divider, one quotient bit per cycle
module tpsp_div
    import tpsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [T_W-1:0]   denom,
    output logic             last,
    output logic [NUM_W-1:0] quot
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [T_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [T_W-1:0]   den_reg, den_next;

    logic [T_W:0]     shifted;
    logic             ge;

    // one trial subtract
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign last    = busy_reg && (cnt_reg == '0);
    assign quot    = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? T_W'(shifted - {1'b0, den_reg}) : shifted[T_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

FILE: rtl/core/trapezoid_position_speed_profile_top.sv
// Trapezoidal speed profile for a two-wheel base. A start item (action 0) turns
// a signed amount into a travel in encoder counts with the Q8.8 scale of its
// kind, latches the start position and answers with the first sample's speeds;
// each sample item (action 1) answers with left/right speeds, phase and done.
// One item is worked at a time and in_stall stays high until it is finished.
// Items on a ramp, a start with nonzero travel among them, go from one
// acceptance to the next through these steps: locate the position, multiply,
// divide bit-serially by the travel, add and saturate, hand off the result,
// and return to idle to take the next item. Cruise samples skip the multiply
// and divide; finished and idle items and zero-travel starts also skip the add
// and saturate. The hand-off waits while the output register holds a stalled
// result.
// A finished result waits in the output register while the next item is taken.
// Configuration writes are always ready and belong to idle periods.
module trapezoid_position_speed_profile_top
    import tpsp_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int SPEED_WIDTH    = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic                          move_kind,
    input  logic signed [7:0]             amount,
    input  logic signed [31:0]            encoder_count,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SPEED_WIDTH-1:0] left_speed,
    output logic signed [SPEED_WIDTH-1:0] right_speed,
    output logic [1:0]                    phase,
    output logic                          done_res
);

    localparam int PW = POSITION_WIDTH;
    localparam int SW = SPEED_WIDTH;
    localparam logic signed [S_W-1:0] SMAX_S =
        $signed((S_W'(1) << (SW - 1)) - S_W'(1));
    localparam logic signed [S_W-1:0] SMIN_S = -SMAX_S - $signed(S_W'(1));
    localparam logic [SW-1:0] SMAX_W = SMAX_S[SW-1:0];
    localparam logic [SW-1:0] SMIN_W = SMIN_S[SW-1:0];

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_SAT  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [14:0]        min_reg, min_next;
    logic [14:0]        max_reg, max_next;
    logic signed [15:0] tscale_reg, tscale_next;
    logic signed [15:0] dscale_reg, dscale_next;

    // move state
    logic [PW-1:0]             start_reg, start_next;
    logic signed [TRAVEL_W-1:0] travel_reg, travel_next;
    logic                      turning_reg, turning_next;
    logic                      moving_reg, moving_next;

    // per-item working registers
    logic [PW-1:0]   enc_reg, enc_next;
    logic [MAG_W-1:0] m_reg, m_next;
    logic [K_W-1:0]  k_reg, k_next;
    logic            ksign_reg, ksign_next;
    logic            cruise_reg, cruise_next;

    // finished result and output register
    logic [SW-1:0] res_left_reg, res_left_next;
    logic [SW-1:0] res_right_reg, res_right_next;
    logic [1:0]    res_phase_reg, res_phase_next;
    logic          res_done_reg, res_done_next;
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] out_left_reg, out_left_next;
    logic [SW-1:0] out_right_reg, out_right_next;
    logic [1:0]    out_phase_reg, out_phase_next;
    logic          out_done_reg, out_done_next;

    logic in_take;
    logic out_free;

    // start decode
    logic signed [15:0]   scale_sel;
    logic signed [23:0]   prod;
    logic signed [63:0]   enc_ext;

    // position evaluation
    logic [PW-1:0]        diff;
    logic                 dneg;
    logic [PW-1:0]        a_full;
    logic [63:0]          a64;
    logic [MAG_W-1:0]     a_cap;
    logic                 neg;
    logic [TRAVEL_W-1:0]  t_wide;
    logic [T_W-1:0]       t_mag;
    logic signed [P_W-1:0] p_pos;
    logic signed [P_W-1:0] p_val;
    logic signed [P_W-1:0] p3;
    logic signed [P_W-1:0] t_s;
    logic signed [P_W-1:0] t_left;
    logic                 reached;
    logic                 in_first;
    logic                 in_middle;
    logic signed [15:0]   span;
    logic [15:0]          span_mag;
    logic [K_W-1:0]       k_c;

    // divider
    logic [NUM_W-1:0] numer;
    logic             div_last;
    logic [NUM_W-1:0] quot;

    // speed sum and saturation
    logic signed [S_W-1:0] base;
    logic signed [S_W-1:0] base_s;
    logic signed [S_W-1:0] q_s;
    logic signed [S_W-1:0] s_sum;
    logic signed [S_W-1:0] s_sat;
    logic [SW-1:0]         left_c;
    logic [SW-1:0]         right_c;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign left_speed  = out_left_reg;
    assign right_speed = out_right_reg;
    assign phase       = out_phase_reg;
    assign done_res    = out_done_reg;

    // travel = floor(amount * scale / 256)
    assign scale_sel = move_kind ? dscale_reg : tscale_reg;
    assign prod      = 24'(amount * scale_sel);
    assign enc_ext   = 64'(encoder_count);

    // distance from start, capped magnitude, taken in travel direction
    assign diff    = enc_reg - start_reg;
    assign dneg    = diff[PW-1];
    assign a_full  = dneg ? (PW'(0) - diff) : diff;
    assign a64     = 64'(a_full);
    assign a_cap   = (a64 > DIST_CAP) ? DIST_CAP[MAG_W-1:0] : a64[MAG_W-1:0];
    assign neg     = travel_reg[TRAVEL_W-1];
    assign t_wide  = neg ? (TRAVEL_W'(0) - travel_reg) : travel_reg;
    assign t_mag   = t_wide[T_W-1:0];
    assign p_pos   = $signed({3'b000, a_cap});
    assign p_val   = (dneg ^ neg) ? -p_pos : p_pos;
    assign p3      = p_val + (p_val <<< 1);
    assign t_s     = $signed(P_W'(t_mag));
    assign t_left  = t_s - p_val;
    assign reached = p_val >= t_s;
    assign in_first  = p3 < t_s;
    assign in_middle = p3 < (t_s <<< 1);

    // 3 * (max - min)
    assign span     = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign span_mag = span[15] ? (16'd0 - span) : span;
    assign k_c      = K_W'(span_mag) + (K_W'(span_mag) << 1);

    assign numer = NUM_W'(k_reg) * NUM_W'(m_reg);

    tpsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_MUL),
        .numer (numer),
        .denom (t_mag),
        .last  (div_last),
        .quot  (quot)
    );

    // signed speed, direction applied, saturated
    assign base   = $signed(S_W'(cruise_reg ? max_reg : min_reg));
    assign base_s = neg ? -base : base;
    assign q_s    = $signed({2'b00, quot});
    assign s_sum  = cruise_reg ? base_s : (base_s + ((ksign_reg ^ neg) ? -q_s : q_s));
    assign s_sat  = (s_sum > SMAX_S) ? SMAX_S : ((s_sum < SMIN_S) ? SMIN_S : s_sum);
    assign left_c = s_sat[SW-1:0];
    assign right_c = turning_reg ? ((left_c == SMIN_W) ? SMAX_W : (SW'(0) - left_c))
                                 : left_c;

    // configuration writes
    always_comb
    begin
        min_next    = min_reg;
        max_next    = max_reg;
        tscale_next = tscale_reg;
        dscale_next = dscale_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_SPEED:   min_next    = cfg_data[14:0];
                REG_MAX_SPEED:   max_next    = cfg_data[14:0];
                REG_TURN_SCALE:  tscale_next = $signed(cfg_data);
                REG_DRIVE_SCALE: dscale_next = $signed(cfg_data);
                default:         min_next    = min_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        travel_next    = travel_reg;
        turning_next   = turning_reg;
        moving_next    = moving_reg;
        enc_next       = enc_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        ksign_next     = ksign_reg;
        cruise_next    = cruise_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_phase_next = res_phase_reg;
        res_done_next  = res_done_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_phase_next = out_phase_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    enc_next = enc_ext[PW-1:0];
                    if (action == ACT_START)
                    begin
                        start_next   = enc_ext[PW-1:0];
                        travel_next  = prod[23:8];
                        turning_next = !move_kind;
                        moving_next  = (prod[23:8] != '0);
                    end
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cruise_next    = 1'b0;
                res_left_next  = '0;
                res_right_next = '0;
                res_phase_next = PH_IDLE;
                res_done_next  = 1'b1;
                k_next         = k_c;
                ksign_next     = span[15];
                if (!moving_reg)
                begin
                    state_next = S_FIN;
                end
                else if (reached)
                begin
                    moving_next = 1'b0;
                    state_next  = S_FIN;
                end
                else if (in_first)
                begin
                    res_done_next  = 1'b0;
                    res_phase_next = PH_ACCEL;
                    m_next         = a_cap;
                    state_next     = S_MUL;
                end
                else if (in_middle)
                begin
                    res_done_next  = 1'b0;
                    res_phase_next = PH_CRUISE;
                    cruise_next    = 1'b1;
                    state_next     = S_SAT;
                end
                else
                begin
                    res_done_next  = 1'b0;
                    res_phase_next = PH_DECEL;
                    m_next         = t_left[MAG_W-1:0];
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                res_left_next  = left_c;
                res_right_next = right_c;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_left_next  = res_left_reg;
                    out_right_next = res_right_reg;
                    out_phase_next = res_phase_reg;
                    out_done_next  = res_done_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= 15'd2621;
            max_reg       <= 15'd16384;
            tscale_reg    <= -16'sd7698;
            dscale_reg    <= 16'sd17779;
            start_reg     <= '0;
            travel_reg    <= '0;
            turning_reg   <= 1'b0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            tscale_reg    <= tscale_next;
            dscale_reg    <= dscale_next;
            start_reg     <= start_next;
            travel_reg    <= travel_next;
            turning_reg   <= turning_next;
            moving_reg    <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        enc_reg       <= enc_next;
        m_reg         <= m_next;
        k_reg         <= k_next;
        ksign_reg     <= ksign_next;
        cruise_reg    <= cruise_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_phase_reg <= res_phase_next;
        res_done_reg  <= res_done_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_phase_reg <= out_phase_next;
        out_done_reg  <= out_done_next;
    end

endmodule

FILE: test/tpsp_profile_checker.sv
// Watches the configuration, item and result channels of the speed profile
// block, predicts each result from the items taken and compares field by field.
module tpsp_profile_checker
    import tpsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic               move_kind,
    input  logic signed [7:0]  amount,
    input  logic signed [31:0] encoder_count,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] left_speed,
    input  logic signed [15:0] right_speed,
    input  logic [1:0]         phase,
    input  logic               done_res,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    // Register values after reset
    localparam logic [14:0]        RST_MIN_SPEED   = 15'd2621;
    localparam logic [14:0]        RST_MAX_SPEED   = 15'd16384;
    localparam logic signed [15:0] RST_TURN_SCALE  = -16'sd7698;
    localparam logic signed [15:0] RST_DRIVE_SCALE = 16'sd17779;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [1:0]         phase;
        logic               done;
    } speed_cmd_t;

    speed_cmd_t expected_cmds[$];
    speed_cmd_t oldest;

    // Register copy
    logic [14:0]        min_q;
    logic [14:0]        max_q;
    logic signed [15:0] turn_scale_q;
    logic signed [15:0] drive_scale_q;

    // Move state
    logic [31:0] start_q;
    longint      travel_q;
    logic        turning_q;
    logic        moving_q;

    function automatic logic signed [15:0] clamp_speed(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Speeds, phase and done for one item; a start latches a new move first
    function automatic speed_cmd_t predict_speeds(input logic act, input logic drive,
                                                  input logic signed [7:0] amt,
                                                  input logic [31:0] enc);
        longint     scale;
        longint     prod;
        longint     t;
        longint     d;
        longint     a;
        longint     mn;
        longint     mx;
        longint     span;
        longint     s;
        logic [31:0] diff;
        logic       neg;
        speed_cmd_t r;
        r.left  = '0;
        r.right = '0;
        r.phase = PH_IDLE;
        r.done  = 1'b1;
        if (act == ACT_START)
        begin
            scale = drive ? drive_scale_q : turn_scale_q;
            prod = amt * scale;
            // floor division by 256
            travel_q  = (prod >= 0) ? prod / 256 : -((-prod + 255) / 256);
            turning_q = !drive;
            start_q   = enc;
            moving_q  = (travel_q != 0);
        end
        if (!moving_q)
            return r;
        neg = (travel_q < 0);
        t = neg ? -travel_q : travel_q;
        // signed distance from the start, modulo 2^32
        diff = enc - start_q;
        if (diff[31])
        begin
            a = 64'sh1_0000_0000 - longint'({32'd0, diff});
            d = -a;
        end
        else
        begin
            a = longint'({32'd0, diff});
            d = a;
        end
        if (neg)
            d = -d;
        // target reached ends the move
        if (d >= t)
        begin
            moving_q = 1'b0;
            return r;
        end
        mn = min_q;
        mx = max_q;
        span = 3 * (mx - mn);
        if (3 * d < t)
        begin
            r.phase = PH_ACCEL;
            s = mn + span * a / t;
        end
        else if (3 * d < 2 * t)
        begin
            r.phase = PH_CRUISE;
            s = mx;
        end
        else
        begin
            r.phase = PH_DECEL;
            s = mn + span * (t - d) / t;
        end
        if (neg)
            s = -s;
        r.left  = clamp_speed(s);
        r.right = turning_q ? clamp_speed(-longint'(r.left)) : r.left;
        r.done  = 1'b0;
        return r;
    endfunction

    // Track writes, check results, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_q         = RST_MIN_SPEED;
            max_q         = RST_MAX_SPEED;
            turn_scale_q  = RST_TURN_SCALE;
            drive_scale_q = RST_DRIVE_SCALE;
            start_q       = '0;
            travel_q      = 0;
            turning_q     = 1'b0;
            moving_q      = 1'b0;
            expected_cmds.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_SPEED:   min_q = cfg_data[14:0];
                    REG_MAX_SPEED:   max_q = cfg_data[14:0];
                    REG_TURN_SCALE:  turn_scale_q = cfg_data;
                    REG_DRIVE_SCALE: drive_scale_q = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("result with no item waiting: left_speed %0d right_speed %0d",
                           left_speed, right_speed);
                    errors++;
                end
                else
                begin
                    oldest = expected_cmds.pop_front();
                    checked++;
                    if (left_speed !== oldest.left)
                    begin
                        $error("left_speed mismatch: expected %0d, actual %0d",
                               oldest.left, left_speed);
                        errors++;
                    end
                    if (right_speed !== oldest.right)
                    begin
                        $error("right_speed mismatch: expected %0d, actual %0d",
                               oldest.right, right_speed);
                        errors++;
                    end
                    if (phase !== oldest.phase)
                    begin
                        $error("phase mismatch: expected %0d, actual %0d", oldest.phase, phase);
                        errors++;
                    end
                    if (done_res !== oldest.done)
                    begin
                        $error("done_res mismatch: expected %0d, actual %0d",
                               oldest.done, done_res);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_cmds.push_back(predict_speeds(action, move_kind, amount, encoder_count));
            pending = expected_cmds.size();
        end
    end

endmodule

FILE: test/trapezoid_position_speed_profile_top_tb.sv
// Stimulus and verdict for the speed profile block; checking is in the checker.
module trapezoid_position_speed_profile_top_tb
    import tpsp_pkg::*;
();

    localparam logic KIND_TURN         = 1'b0;
    localparam logic KIND_DRIVE        = 1'b1;
    localparam int   WATCHDOG_LIMIT    = 4000;
    localparam int   ITEMS_PER_SETTING = 105;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action = 1'b0;
    logic               move_kind = 1'b0;
    logic signed [7:0]  amount = '0;
    logic signed [31:0] encoder_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [1:0]         phase;
    logic               done_res;

    int errors;
    int pending;
    int checked;

    int items_sent = 0;
    int moves_sent = 0;
    int settings_used = 1;
    int burst_left = 0;
    int idle_cycles = 0;

    // Scales in force, used only to aim samples along the travel (reset values first)
    logic signed [15:0] cur_turn_scale = -16'sd7698;
    logic signed [15:0] cur_drive_scale = 16'sd17779;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          run_left = 0;

    trapezoid_position_speed_profile_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .move_kind(move_kind),
        .amount(amount),
        .encoder_count(encoder_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_speed(left_speed),
        .right_speed(right_speed),
        .phase(phase),
        .done_res(done_res)
    );

    tpsp_profile_checker profile_chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .move_kind(move_kind),
        .amount(amount),
        .encoder_count(encoder_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_speed(left_speed),
        .right_speed(right_speed),
        .phase(phase),
        .done_res(done_res),
        .errors(errors),
        .pending(pending),
        .checked(checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side stalls: none, random, or runs of random length
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 12);
                    out_stall <= !out_stall;
                end
                else
                    run_left--;
            end
        endcase
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One item, held until taken; bursts end in a random gap
    task automatic send_item(input logic act, input logic kind, input logic signed [7:0] amt,
                             input logic [31:0] enc);
        in_valid <= 1'b1;
        action <= act;
        move_kind <= kind;
        amount <= amt;
        encoder_count <= enc;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (act == ACT_START)
            moves_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Hold off until every queued result is back and the block is quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Back-to-back writes keep cfg_valid high; the caller lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [14:0] mn, input logic [14:0] mx,
                                 input logic signed [15:0] ts, input logic signed [15:0] ds);
        logic pad;
        pad = 1'($urandom_range(0, 1));
        wait_idle();
        // unused top bit of the speed registers toggled too
        write_reg(REG_MIN_SPEED, {pad, mn});
        write_reg(REG_MAX_SPEED, {!pad, mx});
        write_reg(REG_TURN_SCALE, ts);
        write_reg(REG_DRIVE_SCALE, ds);
        cfg_valid <= 1'b0;
        cur_turn_scale = ts;
        cur_drive_scale = ds;
        settings_used++;
    endtask

    // A start followed by samples walking the travel, with boundary hits,
    // backward steps and wild positions mixed in
    task automatic random_move();
        logic              kind;
        logic signed [7:0] amt;
        logic [31:0]       base;
        logic [31:0]       pos;
        longint            tr;
        longint            t_abs;
        longint            off;
        int                n;
        int                pick;
        int                jit;
        kind = 1'($urandom_range(0, 1));
        amt = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0)
            amt = '0;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            base = 32'h7FFF_FF00 + $urandom_range(0, 511);
        else if (pick == 1)
            base = 32'hFFFF_FF00 + $urandom_range(0, 511);
        else
            base = $urandom;
        tr = (longint'(amt) * (kind ? cur_drive_scale : cur_turn_scale)) / 256;
        t_abs = (tr < 0) ? -tr : tr;
        send_item(ACT_START, kind, amt, base);
        n = $urandom_range(2, 10);
        for (int i = 1; i <= n; i++)
        begin
            pick = $urandom_range(0, 19);
            jit = int'($urandom_range(0, 2)) - 1;
            if (pick < 2)
                off = -longint'($urandom_range(0, int'(t_abs) + 4));
            else if (pick == 2)
                off = longint'($signed($urandom));
            else if (pick < 5)
                off = t_abs / 3 + jit;
            else if (pick < 7)
                off = (2 * t_abs) / 3 + jit;
            else
                off = (t_abs * i) / n + jit;
            if (tr < 0)
                off = -off;
            pos = base + off[31:0];
            send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pos);
        end
        // usually finish on or just past the target
        if ($urandom_range(0, 9) < 6)
        begin
            off = t_abs + $urandom_range(0, 3);
            if (tr < 0)
                off = -off;
            pos = base + off[31:0];
            send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pos);
        end
    endtask

    task automatic run_random(input int quota);
        int stop_at;
        int pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                // stray sample, often while idle
                send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom);
            else if (pick == 1)
                // start cut short by the next start
                send_item(ACT_START, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom);
            else if (pick == 2)
                wait_idle();
            else
                random_move();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed moves under reset register values
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'd0);
        // drive of 8820 counts across the positive wrap, cruise from 2940, decel from 5880
        send_item(ACT_START, KIND_DRIVE, 8'sd127, 32'h7FFF_FFF0);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd1000);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd2939);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd2940);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd5880);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd8818);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFF0 + 32'd8819);
        // positive turn from the most negative count, with backward motion and overshoot
        send_item(ACT_START, KIND_TURN, 8'sh80, 32'h8000_0000);
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'h8000_0000 - 32'd500);
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'h8000_0000 + 32'd1283);
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'h8000_0000 + 32'd3000);
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'h8000_0000 + 32'd5000);
        send_item(ACT_SAMPLE, KIND_TURN, 8'sd0, 32'h8000_0000);
        // negative turn from all ones
        send_item(ACT_START, KIND_TURN, 8'sd127, 32'hFFFF_FFFF);
        send_item(ACT_SAMPLE, KIND_TURN, -8'sd1, 32'hFFFF_FFFF - 32'd3000);
        send_item(ACT_SAMPLE, KIND_TURN, -8'sd1, 32'h0000_0000);
        // zero travel finishes at once
        send_item(ACT_START, KIND_DRIVE, 8'sd0, 32'h7FFF_FFFF);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h1234_5678);
        // short negative drive, huge backward step saturates, then target
        send_item(ACT_START, KIND_DRIVE, -8'sd1, 32'd0);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'h7FFF_FFFF);
        send_item(ACT_SAMPLE, KIND_DRIVE, 8'sd0, 32'hFFFF_FFBA);

        // Random moves under a sequence of register settings
        apply_setting(15'd2621, 15'd16384, -16'sd7698, 16'sd17779);
        run_random(ITEMS_PER_SETTING);
        apply_setting(15'd0, 15'd32767, 16'sh7FFF, 16'sh8000);
        run_random(ITEMS_PER_SETTING);
        apply_setting(15'd32767, 15'd0, 16'sh8000, 16'sh7FFF);
        run_random(ITEMS_PER_SETTING);
        apply_setting(15'd0, 15'd0, 16'sd0, 16'sd256);
        run_random(ITEMS_PER_SETTING);
        apply_setting(15'd32767, 15'd32767, 16'sd3, -16'sd5);
        run_random(ITEMS_PER_SETTING);
        repeat (3)
        begin
            apply_setting(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            run_random(ITEMS_PER_SETTING);
        end

        wait_idle();
        repeat (60) @(negedge clk);
        $display("Covered wrap, third-boundary, backward and saturation moves, then random ones");
        $display("Summary: %0d items in %0d moves under %0d register settings, %0d compared",
                 items_sent, moves_sent, settings_used, checked);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
